FILE: rtl/odd_pkg.sv
package odd_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned RatioW = 24;
  localparam int unsigned CoordW = 16;
  localparam int unsigned BiasW  = 16;
  localparam int unsigned ProdW  = PixW + RatioW;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = RatioW;

  localparam logic [RatioW-1:0] RatioReset = 24'h01_0000;
  localparam logic [PixW-1:0]   OpaqueLevelReset = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RATIO_RED    = 3'd0,
    REG_RATIO_GREEN  = 3'd1,
    REG_RATIO_BLUE   = 3'd2,
    REG_RATIO_ALPHA  = 3'd3,
    REG_ALPHA_ABSENT = 3'd4,
    REG_OPAQUE_LEVEL = 3'd5
  } odd_reg_e;

  // Advance strobes for the product and result stages
  typedef struct packed {
    logic s2;
    logic s3;
  } odd_adv_t;

  // 4x4 Bayer matrix, indexed [row][column], each entry scaled by 4096
  function automatic logic [BiasW-1:0] bayer_bias(input logic [1:0] mx,
                                                  input logic [1:0] my);
    logic [3:0] entry;
    unique case ({my, mx})
      4'b00_00: entry = 4'd0;
      4'b00_01: entry = 4'd8;
      4'b00_10: entry = 4'd2;
      4'b00_11: entry = 4'd10;
      4'b01_00: entry = 4'd12;
      4'b01_01: entry = 4'd4;
      4'b01_10: entry = 4'd14;
      4'b01_11: entry = 4'd6;
      4'b10_00: entry = 4'd3;
      4'b10_01: entry = 4'd11;
      4'b10_10: entry = 4'd1;
      4'b10_11: entry = 4'd9;
      4'b11_00: entry = 4'd15;
      4'b11_01: entry = 4'd7;
      4'b11_10: entry = 4'd13;
      default:  entry = 4'd5;
    endcase
    return {entry, 12'd0};
  endfunction

endpackage

FILE: rtl/odd_lane.sv
module odd_lane (
  input  logic                          clk_i,
  input  odd_pkg::odd_adv_t             adv_i,
  input  logic [odd_pkg::PixW-1:0]      value_i,
  input  logic [odd_pkg::RatioW-1:0]    ratio_i,
  input  logic [odd_pkg::BiasW-1:0]     bias_i,
  output logic [odd_pkg::PixW-1:0]      result_o
);

  logic [odd_pkg::ProdW-1:0]   prod_d, prod_q;
  logic [odd_pkg::BiasW-1:0]   bias_q;
  logic [odd_pkg::ProdW:0]     sum;
  logic [odd_pkg::ProdW-16:0]  shifted;
  logic [odd_pkg::PixW-1:0]    result_d, result_q;

  assign prod_d = odd_pkg::ProdW'(value_i) * odd_pkg::ProdW'(ratio_i);

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      prod_q <= prod_d;
      bias_q <= bias_i;
    end
  end

  // Round, drop the fraction, saturate to the top code
  always_comb begin
    sum      = {1'b0, prod_q} + (odd_pkg::ProdW+1)'(bias_q) + (odd_pkg::ProdW+1)'(1);
    shifted  = sum[odd_pkg::ProdW:16];
    result_d = (|shifted[odd_pkg::ProdW-16:odd_pkg::PixW]) ? '1
                                                            : shifted[odd_pkg::PixW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

FILE: rtl/ordered_dither_depth_reduce.sv
// Ordered-dither depth reducer with a 4x4 Bayer bias.
// Input channel: valid_i / stall_o carry one pixel word (column, row and the
// four raw channels). Output channel: valid_o / stall_i carry one result word
// (red, green, blue, alpha at destination depth). A word moves on a rising
// edge where valid is high and stall is low.
// Configuration: cfg_we_i writes cfg_data_i into the register at cfg_index_i
// (0..3 ratios in 8.16, 4 alpha_absent, 5 opaque alpha level); other indexes
// are ignored. Write only while no pixel is in flight.
// Three registers lie between input accept and output accept: input register,
// 8x24 multiply register, round/saturate result register, and valid_o is the
// valid bit of the last. One pixel is taken every cycle while the output is
// not stalled; each stage is freed as soon as the next one can take its word,
// so a stall at the output fills the three stages and then raises stall_o,
// and no word is lost or repeated.
// Reset clears all stage valid bits and returns the ratios to 1.0,
// alpha_absent to 0 and the opaque alpha level to 255.
module ordered_dither_depth_reduce (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            stall_o,
  input  logic [odd_pkg::CoordW-1:0]      column_i,
  input  logic [odd_pkg::CoordW-1:0]      row_i,
  input  logic [odd_pkg::PixW-1:0]        red_in_i,
  input  logic [odd_pkg::PixW-1:0]        green_in_i,
  input  logic [odd_pkg::PixW-1:0]        blue_in_i,
  input  logic [odd_pkg::PixW-1:0]        alpha_in_i,
  output logic                            valid_o,
  input  logic                            stall_i,
  output logic [odd_pkg::PixW-1:0]        red_out_o,
  output logic [odd_pkg::PixW-1:0]        green_out_o,
  output logic [odd_pkg::PixW-1:0]        blue_out_o,
  output logic [odd_pkg::PixW-1:0]        alpha_out_o,
  input  logic                            cfg_we_i,
  input  logic [odd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [odd_pkg::CfgDataW-1:0]    cfg_data_i
);

  logic [odd_pkg::RatioW-1:0] ratio_red_q, ratio_green_q, ratio_blue_q, ratio_alpha_q;
  logic                       alpha_absent_q;
  logic [odd_pkg::PixW-1:0]   opaque_level_q;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  odd_pkg::odd_adv_t adv;

  logic [1:0]               mx_q, my_q;
  logic [odd_pkg::PixW-1:0] red_q, green_q, blue_q, alpha_q;
  logic [odd_pkg::BiasW-1:0] bias;
  logic [odd_pkg::PixW-1:0] red_res, green_res, blue_res, alpha_res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_red_q    <= odd_pkg::RatioReset;
      ratio_green_q  <= odd_pkg::RatioReset;
      ratio_blue_q   <= odd_pkg::RatioReset;
      ratio_alpha_q  <= odd_pkg::RatioReset;
      alpha_absent_q <= 1'b0;
      opaque_level_q <= odd_pkg::OpaqueLevelReset;
    end else if (cfg_we_i) begin
      unique case (odd_pkg::odd_reg_e'(cfg_index_i))
        odd_pkg::REG_RATIO_RED:    ratio_red_q    <= cfg_data_i;
        odd_pkg::REG_RATIO_GREEN:  ratio_green_q  <= cfg_data_i;
        odd_pkg::REG_RATIO_BLUE:   ratio_blue_q   <= cfg_data_i;
        odd_pkg::REG_RATIO_ALPHA:  ratio_alpha_q  <= cfg_data_i;
        odd_pkg::REG_ALPHA_ABSENT: alpha_absent_q <= cfg_data_i[0];
        odd_pkg::REG_OPAQUE_LEVEL: opaque_level_q <= cfg_data_i[odd_pkg::PixW-1:0];
        default: ;
      endcase
    end
  end

  // A stage takes a new word when it is empty or its word moves on
  assign en3     = !v3_q || !stall_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;
  assign adv.s2  = en2;
  assign adv.s3  = en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mx_q    <= column_i[1:0];
      my_q    <= row_i[1:0];
      red_q   <= red_in_i;
      green_q <= green_in_i;
      blue_q  <= blue_in_i;
      alpha_q <= alpha_in_i;
    end
  end

  assign bias = odd_pkg::bayer_bias(mx_q, my_q);

  odd_lane u_lane_red (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .value_i  (red_q),
    .ratio_i  (ratio_red_q),
    .bias_i   (bias),
    .result_o (red_res)
  );

  odd_lane u_lane_green (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .value_i  (green_q),
    .ratio_i  (ratio_green_q),
    .bias_i   (bias),
    .result_o (green_res)
  );

  odd_lane u_lane_blue (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .value_i  (blue_q),
    .ratio_i  (ratio_blue_q),
    .bias_i   (bias),
    .result_o (blue_res)
  );

  // Alpha is scaled without dither
  odd_lane u_lane_alpha (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .value_i  (alpha_q),
    .ratio_i  (ratio_alpha_q),
    .bias_i   ('0),
    .result_o (alpha_res)
  );

  assign valid_o     = v3_q;
  assign red_out_o   = red_res;
  assign green_out_o = green_res;
  assign blue_out_o  = blue_res;
  assign alpha_out_o = alpha_absent_q ? opaque_level_q : alpha_res;

endmodule
